/* hdl/sao_pkg.sv */
// ----------------------------------------------------------------------------
// sao_pkg
// Shared types, register indexes and helpers of the sprite alpha overlay.
// ----------------------------------------------------------------------------
package sao_pkg;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANCHOR_X       = 3'd0,
		CFG_ANCHOR_Y       = 3'd1,
		CFG_SHIFT_X        = 3'd2,
		CFG_LIFT_Y         = 3'd3,
		CFG_OVERLAY_WIDTH  = 3'd4,
		CFG_OVERLAY_HEIGHT = 3'd5
	} cfg_idx_t;

	// item kind carried on tuser
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_BLEND = 1'b1;

	// stream widths
	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 24;

	// result queue
	localparam int unsigned OQ_DEPTH = 8;
	localparam int unsigned OQ_AW    = 3;
	localparam int unsigned OQ_CW    = 4;

	// store word, chan0 in the low byte
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] chan2;
		logic [7:0] chan1;
		logic [7:0] chan0;
	} pix_t;

	typedef struct packed {
		logic [7:0] chan2;
		logic [7:0] chan1;
		logic [7:0] chan0;
	} rgb_t;

	// window decision for one item
	typedef struct packed {
		logic blend;
		logic hit;
		logic load_ok;
	} win_t;

	// floor(n/255), exact for n up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] n);
		logic [16:0] t;
		t = {1'b0, n} + 17'(n[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

/* hdl/sao_window.sv */
// ----------------------------------------------------------------------------
// sao_window
// Configuration registers and overlay window geometry for each input word.
// ----------------------------------------------------------------------------
module sao_window import sao_pkg::*; #(
	parameter int unsigned MAX_OVERLAY_W = 256,
	parameter int unsigned MAX_OVERLAY_H = 256,
	parameter int unsigned XB = 8,
	parameter int unsigned YB = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  mode,
	input  logic [10:0]           pos_x,
	input  logic [10:0]           pos_y,
	output win_t                  win,
	output logic [XB-1:0]         col,
	output logic [YB-1:0]         row
);

	localparam logic signed [13:0] MAXW_S = 14'(MAX_OVERLAY_W);
	localparam logic signed [13:0] MAXH_S = 14'(MAX_OVERLAY_H);
	localparam logic [10:0]        MAXW_U = 11'(MAX_OVERLAY_W);
	localparam logic [10:0]        MAXH_U = 11'(MAX_OVERLAY_H);

	logic [10:0] anchor_x_q;
	logic [10:0] anchor_y_q;
	logic [9:0]  shift_x_q;
	logic [11:0] lift_y_q;
	logic [8:0]  width_q;
	logic [8:0]  height_q;

	logic signed [13:0] half, half_adj, left, top, fx, fy;
	logic               in_x, in_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			shift_x_q  <= '0;
			lift_y_q   <= '0;
			width_q    <= 9'd1;
			height_q   <= 9'd1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ANCHOR_X:       anchor_x_q <= cfg_data[10:0];
				CFG_ANCHOR_Y:       anchor_y_q <= cfg_data[10:0];
				CFG_SHIFT_X:        shift_x_q  <= cfg_data[9:0];
				CFG_LIFT_Y:         lift_y_q   <= cfg_data[11:0];
				CFG_OVERLAY_WIDTH:  width_q    <= cfg_data[8:0];
				CFG_OVERLAY_HEIGHT: height_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// left edge in half units, then truncate toward zero
		half     = $signed({2'b00, anchor_x_q, 1'b0})
			+ $signed({{3{shift_x_q[9]}}, shift_x_q, 1'b0})
			- $signed({5'b00000, width_q});
		half_adj = half + $signed({13'd0, half[13]});
		left     = half_adj >>> 1;
		top      = $signed({3'b000, anchor_y_q}) - $signed({{2{lift_y_q[11]}}, lift_y_q});
		fx       = $signed({3'b000, pos_x}) - left;
		fy       = $signed({3'b000, pos_y}) - top;

		in_x = !fx[13] && (fx < $signed({5'b00000, width_q})) && (fx < MAXW_S);
		in_y = !fy[13] && (fy < $signed({5'b00000, height_q})) && (fy < MAXH_S);

		win.blend   = (mode == MODE_BLEND);
		win.hit     = (mode == MODE_BLEND) && in_x && in_y;
		win.load_ok = (mode == MODE_LOAD) && (pos_x < MAXW_U) && (pos_y < MAXH_U);

		if (mode == MODE_BLEND) begin
			col = fx[XB-1:0];
			row = fy[YB-1:0];
		end else begin
			col = pos_x[XB-1:0];
			row = pos_y[YB-1:0];
		end
	end

endmodule

/* hdl/sao_store.sv */
// ----------------------------------------------------------------------------
// sao_store
// Overlay image store: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sao_store import sao_pkg::*; #(
	parameter int unsigned DEPTH = 65536,
	parameter int unsigned AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  pix_t          wdata,
	output pix_t          rdata
);

	pix_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* hdl/sao_blend.sv */
// ----------------------------------------------------------------------------
// sao_blend
// Per-channel alpha mix: products registered, then exact divide by 255.
// ----------------------------------------------------------------------------
module sao_blend import sao_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic hit,
	input  rgb_t bg,
	input  pix_t fg,
	output logic out_valid,
	output rgb_t out_pix
);

	logic [7:0]  a, inv;
	rgb_t        fg_eff;
	logic [15:0] sum0, sum1, sum2;
	logic [15:0] sum0_s3, sum1_s3, sum2_s3;
	logic        valid_s3;

	always_comb begin
		// outside the window: zero alpha gives the frame pixel back
		a             = hit ? fg.alpha : 8'd0;
		fg_eff.chan0  = hit ? fg.chan0 : 8'd0;
		fg_eff.chan1  = hit ? fg.chan1 : 8'd0;
		fg_eff.chan2  = hit ? fg.chan2 : 8'd0;
		inv           = 8'd255 - a;
		sum0 = 16'(bg.chan0) * 16'(inv) + 16'(fg_eff.chan0) * 16'(a);
		sum1 = 16'(bg.chan1) * 16'(inv) + 16'(fg_eff.chan1) * 16'(a);
		sum2 = 16'(bg.chan2) * 16'(inv) + 16'(fg_eff.chan2) * 16'(a);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sum0_s3 <= sum0;
		sum1_s3 <= sum1;
		sum2_s3 <= sum2;
	end

	assign out_valid     = valid_s3;
	assign out_pix.chan0 = div255(sum0_s3);
	assign out_pix.chan1 = div255(sum1_s3);
	assign out_pix.chan2 = div255(sum2_s3);

endmodule

/* hdl/sao_outq.sv */
// ----------------------------------------------------------------------------
// sao_outq
// Result queue in front of the master side; absorbs words in flight.
// ----------------------------------------------------------------------------
module sao_outq import sao_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rgb_t             push_data,
	output logic             valid,
	input  logic             ready,
	output rgb_t             data,
	output logic [OQ_CW-1:0] count
);

	rgb_t             slots_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic             pop;

	assign valid = (count_q != '0);
	assign data  = slots_q[rd_ptr_q];
	assign count = count_q;
	assign pop   = valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			end
			count_q <= count_q + OQ_CW'(push) - OQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/sprite_alpha_overlay.sv */
// ----------------------------------------------------------------------------
// sprite_alpha_overlay: alpha-blends a stored overlay image onto frame pixels
// A blend word passes s1, the store read, s3 and the result queue to m_tvalid.
// Throughput: one word per cycle if a queue slot is free; one store access per cycle.
// Reset clears pipeline, result queue and registers; store content stays.
// ----------------------------------------------------------------------------
module sprite_alpha_overlay import sao_pkg::*; #(
	parameter int unsigned MAX_OVERLAY_W = 256,
	parameter int unsigned MAX_OVERLAY_H = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // pos_x, pos_y, chan0, chan1, chan2, alpha, pad
	input  logic                  s_tuser,  // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // out_chan0, out_chan1, out_chan2
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned DEPTH = MAX_OVERLAY_W * MAX_OVERLAY_H;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned XB    = (MAX_OVERLAY_W > 1) ? $clog2(MAX_OVERLAY_W) : 1;
	localparam int unsigned YB    = (MAX_OVERLAY_H > 1) ? $clog2(MAX_OVERLAY_H) : 1;

	logic             accept, accept_blend, pop;
	win_t             win, win_s1;
	logic [XB-1:0]    col, col_s1;
	logic [YB-1:0]    row, row_s1;
	logic             valid_s1;
	pix_t             pix_s1;
	logic [AW-1:0]    addr;
	logic             mem_we, mem_re;
	pix_t             fg_s2;
	logic             valid_s2, hit_s2;
	rgb_t             bg_s2;
	logic             res_valid;
	rgb_t             res_pix, q_data;
	logic [OQ_CW-1:0] credits_q, oq_cnt;

	assign accept       = s_tvalid && s_tready;
	assign accept_blend = accept && (s_tuser == MODE_BLEND);
	assign pop          = m_tvalid && m_tready;
	// every blend word holds a queue slot from acceptance until it leaves
	assign s_tready     = (credits_q != OQ_CW'(OQ_DEPTH));

	sao_window #(
		.MAX_OVERLAY_W(MAX_OVERLAY_W),
		.MAX_OVERLAY_H(MAX_OVERLAY_H),
		.XB(XB),
		.YB(YB)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mode(s_tuser),
		.pos_x(s_tdata[10:0]),
		.pos_y(s_tdata[21:11]),
		.win(win),
		.col(col),
		.row(row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			credits_q <= '0;
		end else begin
			valid_s1  <= accept;
			valid_s2  <= valid_s1 && win_s1.blend;
			credits_q <= credits_q + OQ_CW'(accept_blend) - OQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		win_s1 <= win;
		col_s1 <= col;
		row_s1 <= row;
		pix_s1 <= pix_t'(s_tdata[53:22]);
		hit_s2 <= win_s1.hit;
		bg_s2  <= rgb_t'(pix_s1[23:0]);
	end

	// loads and reads share this stage, so a load is visible to the very next read
	assign addr   = AW'(32'(row_s1) * 32'(MAX_OVERLAY_W) + 32'(col_s1));
	assign mem_we = valid_s1 && win_s1.load_ok;
	assign mem_re = valid_s1 && win_s1.hit;

	sao_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.re(mem_re),
		.addr(addr),
		.wdata(pix_s1),
		.rdata(fg_s2)
	);

	sao_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s2),
		.hit(hit_s2),
		.bg(bg_s2),
		.fg(fg_s2),
		.out_valid(res_valid),
		.out_pix(res_pix)
	);

	sao_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.push_data(res_pix),
		.valid(m_tvalid),
		.ready(m_tready),
		.data(q_data),
		.count(oq_cnt)
	);

	assign m_tdata = q_data;

`ifndef ASSERT_OFF
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credits_q <= OQ_CW'(OQ_DEPTH))
		else $error("result credits exceed queue depth");

	a_queue_covered: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt <= credits_q)
		else $error("queued results not covered by credits");

	a_store_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store written and read in the same cycle");

	a_blend_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && win_s1.blend) |=> ##1 res_valid)
		else $error("blend word lost in pipeline");
`endif

endmodule

/* tb/overlay_blend_checker.sv */
// ----------------------------------------------------------------------------
// overlay_blend_checker
// Watches the pixel streams and the register port of the sprite overlay,
// computes every blended frame pixel on its own and compares the results.
// ----------------------------------------------------------------------------
module overlay_blend_checker import sao_pkg::*; #(
	parameter int SPRITE_W = 256,
	parameter int SPRITE_H = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // pos_x, pos_y, chan0, chan1, chan2, alpha, pad
	input  logic                  s_tuser,  // mode
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,  // out_chan0, out_chan1, out_chan2
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	pix_t sprite_mem [0:SPRITE_W*SPRITE_H-1];
	rgb_t blended_q [$];

	logic        [10:0] anchor_x_r;
	logic        [10:0] anchor_y_r;
	logic signed [9:0]  shift_x_r;
	logic signed [11:0] lift_y_r;
	logic        [8:0]  width_r;
	logic        [8:0]  height_r;

	function automatic logic [7:0] mix_channel(input logic [7:0] bg, input logic [7:0] fg,
			input logic [7:0] a);
		int n;
		n = int'(bg) * (255 - int'(a)) + int'(fg) * int'(a);
		return 8'(n / 255);
	endfunction

	function automatic rgb_t blend_pixel(input logic [10:0] px, input logic [10:0] py,
			input rgb_t bg);
		int left_c, top_c, fx, fy, wc, hc;
		pix_t fgp;
		rgb_t res;
		// left edge sits half a width left of the centre, rounded toward zero
		left_c = (2 * int'(anchor_x_r) + 2 * int'(shift_x_r) - int'(width_r)) / 2;
		top_c  = int'(anchor_y_r) - int'(lift_y_r);
		wc = (int'(width_r) < SPRITE_W) ? int'(width_r) : SPRITE_W;
		hc = (int'(height_r) < SPRITE_H) ? int'(height_r) : SPRITE_H;
		fx = int'(px) - left_c;
		fy = int'(py) - top_c;
		res = bg;
		if (fx >= 0 && fx < wc && fy >= 0 && fy < hc) begin
			fgp = sprite_mem[fy * SPRITE_W + fx];
			res.chan0 = mix_channel(bg.chan0, fgp.chan0, fgp.alpha);
			res.chan1 = mix_channel(bg.chan1, fgp.chan1, fgp.alpha);
			res.chan2 = mix_channel(bg.chan2, fgp.chan2, fgp.alpha);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [10:0] px, py;
		rgb_t        bg, want, got;
		if (!arst_n) begin
			anchor_x_r = '0;
			anchor_y_r = '0;
			shift_x_r  = '0;
			lift_y_r   = '0;
			width_r    = 9'd1;
			height_r   = 9'd1;
			blended_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ANCHOR_X:       anchor_x_r = cfg_data[10:0];
					CFG_ANCHOR_Y:       anchor_y_r = cfg_data[10:0];
					CFG_SHIFT_X:        shift_x_r  = cfg_data[9:0];
					CFG_LIFT_Y:         lift_y_r   = cfg_data[11:0];
					CFG_OVERLAY_WIDTH:  width_r    = cfg_data[8:0];
					CFG_OVERLAY_HEIGHT: height_r   = cfg_data[8:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				px = s_tdata[10:0];
				py = s_tdata[21:11];
				bg.chan0 = s_tdata[29:22];
				bg.chan1 = s_tdata[37:30];
				bg.chan2 = s_tdata[45:38];
				if (s_tuser == MODE_LOAD) begin
					// drop loads that fall outside the store
					if (int'(px) < SPRITE_W && int'(py) < SPRITE_H)
						sprite_mem[int'(py) * SPRITE_W + int'(px)] =
							{s_tdata[53:46], bg.chan2, bg.chan1, bg.chan0};
				end else begin
					blended_q.push_back(blend_pixel(px, py, bg));
				end
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (blended_q.size() == 0) begin
					$display("%0t: output word with nothing pending, expected none, got %h",
						$time, got);
					errors++;
				end else begin
					want = blended_q.pop_front();
					for (int k = 0; k < 3; k++) begin
						if (got[8*k +: 8] !== want[8*k +: 8]) begin
							$display("%0t: out_chan%0d mismatch, expected %0d, got %0d",
								$time, k, want[8*k +: 8], got[8*k +: 8]);
							errors++;
						end
					end
				end
			end
			pending = blended_q.size();
		end
	end

endmodule

/* tb/sprite_alpha_overlay_tb.sv */
// ----------------------------------------------------------------------------
// sprite_alpha_overlay_tb
// Loads overlay pixels and streams frame pixels through the overlay block
// under a series of window placements and sizes, with random gaps on the
// input and random back-pressure on the output; the checker scores results.
// ----------------------------------------------------------------------------
module sprite_alpha_overlay_tb import sao_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPRITE_W = 256;
	localparam int SPRITE_H = 256;

	typedef struct packed {
		logic                 mode;
		logic [IN_DATA_W-1:0] payload;
	} pixel_word_t;

	typedef enum int {RX_FREE, RX_COIN, RX_LIGHT, RX_HEAVY} rx_style_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;  // pos_x, pos_y, chan0, chan1, chan2, alpha, pad
	logic                  s_tuser   = MODE_LOAD;  // mode
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;  // out_chan0, out_chan1, out_chan2
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int errors;
	int pending;

	pixel_word_t pixel_words [$];
	bit          loaded_map [0:SPRITE_W*SPRITE_H-1];

	// window as currently programmed, clipped to the store
	int cur_left, cur_top, cur_wc, cur_hc;

	rx_style_t rx_style = RX_FREE;
	int        rx_left  = 0;

	sprite_alpha_overlay #(
		.MAX_OVERLAY_W(SPRITE_W),
		.MAX_OVERLAY_H(SPRITE_H)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	overlay_blend_checker #(
		.SPRITE_W(SPRITE_W),
		.SPRITE_H(SPRITE_H)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// output back-pressure: switch style every so often
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_left  = $urandom_range(16, 200);
		end else begin
			rx_left--;
		end
		case (rx_style)
			RX_FREE:  m_tready <= 1'b1;
			RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
			RX_LIGHT: m_tready <= ($urandom_range(0, 7) != 0);
			default:  m_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	function automatic logic [7:0] pick_alpha();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic queue_load(input int px, input int py, input logic [7:0] c0,
			input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] a);
		pixel_word_t pw;
		pw.mode    = MODE_LOAD;
		pw.payload = {2'b00, a, c2, c1, c0, 11'(py), 11'(px)};
		pixel_words.push_back(pw);
		if (px < SPRITE_W && py < SPRITE_H)
			loaded_map[py * SPRITE_W + px] = 1'b1;
	endtask

	task automatic queue_blend(input int px, input int py, input logic [7:0] c0,
			input logic [7:0] c1, input logic [7:0] c2);
		pixel_word_t pw;
		int fx, fy;
		fx = px - cur_left;
		fy = py - cur_top;
		// never read an overlay pixel that was not loaded
		if (fx >= 0 && fx < cur_wc && fy >= 0 && fy < cur_hc && !loaded_map[fy * SPRITE_W + fx])
			queue_load(fx, fy, 8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
		pw.mode    = MODE_BLEND;
		pw.payload = {2'b00, 8'($urandom), c2, c1, c0, 11'(py), 11'(px)};
		pixel_words.push_back(pw);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(negedge clk);
	endtask

	task automatic apply_settings(input int ax, input int ay, input int sx, input int ly,
			input int w, input int h);
		put_reg(CFG_ANCHOR_X, ax);
		put_reg(CFG_ANCHOR_Y, ay);
		put_reg(CFG_SHIFT_X, sx);
		put_reg(CFG_LIFT_Y, ly);
		put_reg(CFG_OVERLAY_WIDTH, w);
		put_reg(CFG_OVERLAY_HEIGHT, h);
		cfg_we <= 1'b0;
		cur_left = (2 * ax + 2 * sx - w) / 2;
		cur_top  = ay - ly;
		cur_wc   = (w < SPRITE_W) ? w : SPRITE_W;
		cur_hc   = (h < SPRITE_H) ? h : SPRITE_H;
	endtask

	task automatic fill_random(input int n);
		int sel, px, py;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			if (sel < 22) begin
				// refresh overlay pixels the window can reach
				px = (cur_wc > 0) ? $urandom_range(0, cur_wc - 1) : $urandom_range(0, SPRITE_W - 1);
				py = (cur_hc > 0) ? $urandom_range(0, cur_hc - 1) : $urandom_range(0, SPRITE_H - 1);
				queue_load(px, py, 8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
			end else if (sel < 28) begin
				if ($urandom_range(0, 1) == 0) begin
					px = $urandom_range(SPRITE_W, 2047);
					py = $urandom_range(0, 2047);
				end else begin
					px = $urandom_range(0, 2047);
					py = $urandom_range(SPRITE_H, 2047);
				end
				queue_load(px, py, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				if (sel < 80) begin
					// aim at the window and a two-pixel border around it
					px = cur_left + int'($urandom_range(0, cur_wc + 3)) - 2;
					py = cur_top + int'($urandom_range(0, cur_hc + 3)) - 2;
				end else begin
					px = $urandom_range(0, 2047);
					py = $urandom_range(0, 2047);
				end
				if (px < 0 || px > 2047)
					px = $urandom_range(0, 2047);
				if (py < 0 || py > 2047)
					py = $urandom_range(0, 2047);
				queue_blend(px, py, 8'($urandom), 8'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic stream_words();
		pixel_word_t nxt;
		int burst_left, gap;
		burst_left = 0;
		while (pixel_words.size() != 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			nxt = pixel_words.pop_front();
			s_tvalid <= 1'b1;
			s_tuser  <= nxt.mode;
			s_tdata  <= nxt.payload;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			@(negedge clk);
			burst_left--;
		end
		s_tvalid <= 1'b0;
	endtask

	// hold until every blend has come out, then cover the pipeline depth
	task automatic settle();
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic run_phase(input int ax, input int ay, input int sx, input int ly,
			input int w, input int h);
		apply_settings(ax, ay, sx, ly, w, h);
		fill_random(40);
		stream_words();
		settle();
	endtask

	initial begin
		int ax, ay, sx, ly, w, h;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// window at columns 4..8, rows 18..20
		apply_settings(10, 20, -3, 2, 5, 3);
		queue_load(0, 0, 8'd255, 8'd0, 8'd128, 8'd255);
		queue_load(4, 2, 8'd255, 8'd255, 8'd255, 8'd0);
		queue_load(1, 1, 8'd0, 8'd0, 8'd0, 8'd128);
		queue_load(4, 0, 8'd255, 8'd255, 8'd255, 8'd1);
		queue_load(0, 2, 8'd17, 8'd200, 8'd255, 8'd254);
		queue_load(255, 255, 8'd255, 8'd255, 8'd255, 8'd255);
		queue_load(2047, 2047, 8'd255, 8'd255, 8'd255, 8'd255);
		queue_load(256, 0, 8'd1, 8'd2, 8'd3, 8'd255);
		queue_load(0, 256, 8'd1, 8'd2, 8'd3, 8'd255);
		queue_blend(4, 18, 8'd0, 8'd0, 8'd0);
		queue_blend(8, 20, 8'd255, 8'd0, 8'd17);
		queue_blend(5, 19, 8'd255, 8'd255, 8'd255);
		queue_blend(8, 18, 8'd0, 8'd0, 8'd0);
		queue_blend(4, 20, 8'd255, 8'd0, 8'd0);
		queue_blend(3, 18, 8'd1, 8'd2, 8'd3);
		queue_blend(9, 18, 8'd4, 8'd5, 8'd6);
		queue_blend(4, 17, 8'd7, 8'd8, 8'd9);
		queue_blend(4, 21, 8'd10, 8'd11, 8'd12);
		queue_blend(0, 0, 8'd255, 8'd255, 8'd255);
		queue_blend(2047, 2047, 8'd0, 8'd0, 8'd0);
		// overwrite with a clear pixel and read it back at once
		queue_load(0, 0, 8'd9, 8'd9, 8'd9, 8'd0);
		queue_blend(4, 18, 8'd100, 8'd150, 8'd200);
		stream_words();
		settle();

		run_phase(0, 0, 0, 0, 9, 4);                   // left edge -4.5 rounds to -4
		run_phase(1, 0, 0, 1, 3, 5);                   // left edge -0.5 rounds to 0
		run_phase(2047, 2047, 511, -2048, 256, 256);   // window beyond the frame
		run_phase(1000, 500, -512, 2047, 0, 7);        // zero width
		run_phase(300, 300, 0, 0, 256, 0);             // zero height
		run_phase(600, 900, 100, 300, 511, 511);       // clipped to the store
		run_phase(1024, 1024, -1, -1, 256, 256);
		run_phase(5, 2040, 3, -5, 1, 1);
		repeat (4) begin
			ax = $urandom_range(0, 2047);
			ay = $urandom_range(0, 2047);
			sx = int'($urandom_range(0, 1023)) - 512;
			ly = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095)) - 2048 :
				int'($urandom_range(0, 128)) - 64;
			w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 48);
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 48);
			run_phase(ax, ay, sx, ly, w, h);
		end

		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* sprite_alpha_overlay.f */
hdl/sao_pkg.sv
hdl/sao_window.sv
hdl/sao_store.sv
hdl/sao_blend.sv
hdl/sao_outq.sv
hdl/sprite_alpha_overlay.sv
tb/overlay_blend_checker.sv
tb/sprite_alpha_overlay_tb.sv
